### hw/rtl/tcgr_pkg.sv
// shared types and constants of the text console glyph renderer
`default_nettype none
package tcgr_pkg;

    // command kinds from the front end to the drawing back end
    localparam logic [2:0] KIND_LOAD      = 3'd0;
    localparam logic [2:0] KIND_NEWLINE   = 3'd1;
    localparam logic [2:0] KIND_RETURN    = 3'd2;
    localparam logic [2:0] KIND_BACKSPACE = 3'd3;
    localparam logic [2:0] KIND_DRAW      = 3'd4;

    localparam logic MODE_LOAD = 1'b0;

    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_RETURN    = 8'h0D;
    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;

    localparam logic [23:0] COLOR_WHITE = 24'hFFFFFF;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_FRAME_BASE   = 2'd0;
    localparam logic [1:0] CFG_LINE_PITCH   = 2'd1;
    localparam logic [1:0] CFG_BPP          = 2'd2;
    localparam logic [1:0] CFG_SCREEN_WIDTH = 2'd3;

    localparam logic [31:0] RST_FRAME_BASE   = 32'd0;
    localparam logic [15:0] RST_LINE_PITCH   = 16'd3072;
    localparam logic [5:0]  RST_BPP          = 6'd24;
    localparam logic [12:0] RST_SCREEN_WIDTH = 13'd1024;

    localparam int FONT_DEPTH  = 4096;
    localparam int FONT_ADDR_W = 12;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] code;
        logic [3:0] row;
        logic [7:0] bits;
    } t_cmd;

    typedef struct packed {
        logic [31:0] frame_base;
        logic [15:0] line_pitch;
        logic [5:0]  bits_per_pixel;
        logic [12:0] screen_width;
    } t_cfg;

endpackage
`default_nettype wire

### hw/rtl/tcgr_ram.sv
// generic simple dual port ram with registered read
`default_nettype none
module tcgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

### hw/rtl/tcgr_front.sv
// input stage: takes stream beats and classifies them into commands
`default_nettype none
module tcgr_front import tcgr_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_tvalid,
    output logic             o_tready,
    input  wire logic [19:0] i_tdata,
    input  wire logic        i_tuser,
    output logic             o_cmd_valid,
    output t_cmd             o_cmd,
    input  wire logic        i_cmd_ready
);
    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    always_comb begin
        n_cmd.code = i_tdata[7:0];
        n_cmd.row  = i_tdata[11:8];
        n_cmd.bits = i_tdata[19:12];
        if (i_tuser == MODE_LOAD) begin
            n_cmd.kind = KIND_LOAD;
        end else if (i_tdata[7:0] == CHAR_NEWLINE) begin
            n_cmd.kind = KIND_NEWLINE;
        end else if (i_tdata[7:0] == CHAR_RETURN) begin
            n_cmd.kind = KIND_RETURN;
        end else if (i_tdata[7:0] == CHAR_BACKSPACE) begin
            n_cmd.kind = KIND_BACKSPACE;
        end else begin
            n_cmd.kind = KIND_DRAW;
        end
    end

    assign o_tready    = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_tready) begin
            r_valid <= i_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tready && i_tvalid) begin
            r_cmd <= n_cmd;
        end
    end
endmodule
`default_nettype wire

### hw/rtl/tcgr_fifo.sv
// short command queue between front end and back end
`default_nettype none
module tcgr_fifo import tcgr_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    output logic      o_ready,
    output logic      o_valid,
    output t_cmd      o_cmd,
    input  wire logic i_pop
);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [PTR_W:0]   r_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_count != (PTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end
endmodule
`default_nettype wire

### hw/rtl/tcgr_back.sv
// back end: cursor, font store and the pixel pair pipeline
`default_nettype none
module tcgr_back import tcgr_pkg::*; #(
    parameter int GLYPH_WIDTH  = 8,
    parameter int GLYPH_HEIGHT = 16,
    parameter int GLYPH_COUNT  = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  t_cfg             i_cfg,
    input  wire logic        i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_cmd_pop,
    output logic             o_tvalid,
    input  wire logic        i_tready,
    output logic [31:0]      o_pixel_address,
    output logic [23:0]      o_left_color,
    output logic [23:0]      o_right_color,
    output logic             o_last_pair
);
    localparam int PAIRS = (GLYPH_WIDTH + 1) / 2;
    localparam int PAIR_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam int ROW_W = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
    localparam logic [PAIR_W-1:0] LAST_PAIR = PAIR_W'(PAIRS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(GLYPH_HEIGHT - 1);
    localparam logic [15:0] GW16 = 16'(GLYPH_WIDTH);
    localparam logic [15:0] GH16 = 16'(GLYPH_HEIGHT);

    function automatic logic [7:0] f_glyph(input logic [7:0] c);
        logic [8:0] w;
        w = {1'b0, c};
        if (w >= 9'(GLYPH_COUNT)) begin
            w = w - 9'(GLYPH_COUNT);
        end
        return w[7:0];
    endfunction

    // 255 = 2^8 - 1, so the remainder follows from a sum of bytes
    function automatic logic [7:0] f_mod255(input logic [31:0] a);
        logic [9:0] s;
        logic [8:0] t;
        s = 10'(a[7:0]) + 10'(a[15:8]) + 10'(a[23:16]) + 10'(a[31:24]);
        t = 9'(s[7:0]) + 9'(s[9:8]);
        if (t >= 9'd255) begin
            t = t - 9'd255;
        end
        return t[7:0];
    endfunction

    // cursor and command dispatch
    logic [15:0] r_cx, r_cy, n_cx, n_cy;
    logic        start;
    logic [15:0] start_x;
    logic [7:0]  start_glyph;
    logic        ram_we;
    logic [FONT_ADDR_W-1:0] ram_waddr;
    logic [15:0] back_x;

    // pair generator
    logic              r_busy;
    logic [ROW_W-1:0]  r_row;
    logic [PAIR_W-1:0] r_pair;
    logic [15:0]       r_gx, r_gy;
    logic [7:0]        r_glyph;
    logic [3:0]        col_even;
    logic [2:0]        g_col;
    logic              g_last;
    logic              adv;
    logic              ram_re;
    logic [FONT_ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    // pipeline stages
    logic        r_s1_valid, r_s1_last;
    logic [15:0] r_s1_x, r_s1_y;
    logic [15:0] s1_xr;
    logic [2:0]  r_s1_col;
    logic        s1_wl, s1_wr;
    logic        r_s2_valid, r_s2_last, r_s2_wl, r_s2_wr;
    logic [31:0] r_s2_pl, r_s2_pr, r_s2_yp;
    logic [18:0] r_s2_xs;
    logic        r_out_valid;

    assign o_cmd_pop = i_cmd_valid && !r_busy;

    always_comb begin
        n_cx        = r_cx;
        n_cy        = r_cy;
        start       = 1'b0;
        start_x     = r_cx;
        start_glyph = f_glyph(i_cmd.code);
        ram_we      = 1'b0;
        ram_waddr   = {f_glyph(i_cmd.code), i_cmd.row};
        back_x      = r_cx - GW16;
        if (r_cx == 16'd0) begin
            back_x = {3'b000, i_cfg.screen_width} - GW16;
        end
        if (o_cmd_pop) begin
            case (i_cmd.kind)
                KIND_LOAD: begin
                    ram_we = 1'b1;
                end
                KIND_NEWLINE: begin
                    n_cy = r_cy + GH16;
                    n_cx = 16'd0;
                end
                KIND_RETURN: begin
                    n_cx = 16'd0;
                end
                KIND_BACKSPACE: begin
                    // cursor stays on the blanked cell
                    if (r_cx == 16'd0) begin
                        n_cy = r_cy - GH16;
                    end
                    n_cx        = back_x;
                    start       = 1'b1;
                    start_x     = back_x;
                    start_glyph = f_glyph(CHAR_SPACE);
                end
                KIND_DRAW: begin
                    n_cx  = r_cx + GW16;
                    start = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
        end else begin
            r_cx <= n_cx;
            r_cy <= n_cy;
        end
    end

    assign adv = !r_out_valid || i_tready;

    always_comb begin
        col_even = 4'(r_pair) << 1;
        if (col_even + 4'd1 >= 4'(GLYPH_WIDTH)) begin
            g_col = 3'(GLYPH_WIDTH - 2);
        end else begin
            g_col = col_even[2:0];
        end
        g_last    = (r_row == LAST_ROW) && (r_pair == LAST_PAIR);
        ram_re    = adv && r_busy;
        ram_raddr = {r_glyph, 4'(r_row)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (start) begin
            r_busy <= 1'b1;
        end else if (adv && r_busy && g_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_row   <= '0;
            r_pair  <= '0;
            r_gx    <= start_x;
            r_gy    <= n_cy;
            r_glyph <= start_glyph;
        end else if (adv && r_busy) begin
            if (r_pair == LAST_PAIR) begin
                r_pair <= '0;
                r_row  <= r_row + 1'b1;
            end else begin
                r_pair <= r_pair + 1'b1;
            end
        end
    end

    tcgr_ram #(
        .WIDTH (8),
        .DEPTH (FONT_DEPTH)
    ) u_font (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_cmd.bits),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // font row arrives from the ram alongside stage one
    assign s1_wl = ram_rdata[3'(GLYPH_WIDTH - 1) - r_s1_col];
    assign s1_wr = ram_rdata[3'(GLYPH_WIDTH - 2) - r_s1_col];

    // right pixel column wraps at 16 bits like the cursor
    assign s1_xr = r_s1_x + 16'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= r_busy;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_x    <= r_gx + 16'(g_col);
            r_s1_y    <= r_gy + 16'(r_row);
            r_s1_col  <= g_col;
            r_s1_last <= g_last;

            r_s2_pl   <= 32'(r_s1_x) * 32'(r_s1_y);
            r_s2_pr   <= 32'(s1_xr) * 32'(r_s1_y);
            r_s2_yp   <= 32'(r_s1_y) * 32'(i_cfg.line_pitch);
            r_s2_xs   <= 19'(r_s1_x) * 19'(i_cfg.bits_per_pixel[5:3]);
            r_s2_wl   <= s1_wl;
            r_s2_wr   <= s1_wr;
            r_s2_last <= r_s1_last;

            o_pixel_address <= i_cfg.frame_base + r_s2_yp + 32'(r_s2_xs);
            o_left_color    <= r_s2_wl ? COLOR_WHITE : {16'h0000, f_mod255(r_s2_pl)};
            o_right_color   <= r_s2_wr ? COLOR_WHITE : {16'h0000, f_mod255(r_s2_pr)};
            o_last_pair     <= r_s2_last;
        end
    end

    assign o_tvalid = r_out_valid;
endmodule
`default_nettype wire

### hw/rtl/text_console_glyph_renderer_unit.sv
// top level of the text console glyph renderer
//
//  channel     dir  handshake                      payload
//  s_axis      in   s_axis_tvalid / s_axis_tready  tdata: code, row, bits; tuser: mode
//  m_axis      out  m_axis_tvalid / m_axis_tready  tdata: address, colors; tlast: last pair
//  cfg         in   i_cfg_we                       i_cfg_index, i_cfg_wdata
//
// a drawn character is dispatched and then gives one beat per cycle, while m_axis is ready, for
// GLYPH_HEIGHT * ((GLYPH_WIDTH + 1) / 2) pairs (64 at 8x16), paced by the pair generator
// loads, newline and carriage return are taken by the back end at dispatch and give no beat
// after dispatch the first beat passes the pair generator, stage one, stage two and the output
// register; the font store is not cleared by reset and must be loaded before use
// a stalled m_axis freezes the pixel pipeline; s_axis moves on until the four deep queue fills
`default_nettype none
module text_console_glyph_renderer_unit import tcgr_pkg::*; #(
    parameter int GLYPH_WIDTH  = 8,
    parameter int GLYPH_HEIGHT = 16,
    parameter int GLYPH_COUNT  = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // char_code, font_row_index, font_row_bits, pad
    input  wire logic [0:0]  s_axis_tuser,  // mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata,  // pixel_address, left_color, right_color
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_wdata
);
    t_cfg        r_cfg;
    logic        front_valid;
    t_cmd        front_cmd;
    logic        fifo_ready;
    logic        fifo_valid;
    t_cmd        fifo_cmd;
    logic        cmd_pop;
    logic [31:0] pix_addr;
    logic [23:0] left_col;
    logic [23:0] right_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_base     <= RST_FRAME_BASE;
            r_cfg.line_pitch     <= RST_LINE_PITCH;
            r_cfg.bits_per_pixel <= RST_BPP;
            r_cfg.screen_width   <= RST_SCREEN_WIDTH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_BASE:   r_cfg.frame_base     <= i_cfg_wdata;
                CFG_LINE_PITCH:   r_cfg.line_pitch     <= i_cfg_wdata[15:0];
                CFG_BPP:          r_cfg.bits_per_pixel <= i_cfg_wdata[5:0];
                CFG_SCREEN_WIDTH: r_cfg.screen_width   <= i_cfg_wdata[12:0];
                default: begin
                end
            endcase
        end
    end

    tcgr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tvalid    (s_axis_tvalid),
        .o_tready    (s_axis_tready),
        .i_tdata     (s_axis_tdata[19:0]),
        .i_tuser     (s_axis_tuser[0]),
        .o_cmd_valid (front_valid),
        .o_cmd       (front_cmd),
        .i_cmd_ready (fifo_ready)
    );

    tcgr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_cmd   (front_cmd),
        .o_ready (fifo_ready),
        .o_valid (fifo_valid),
        .o_cmd   (fifo_cmd),
        .i_pop   (cmd_pop)
    );

    tcgr_back #(
        .GLYPH_WIDTH  (GLYPH_WIDTH),
        .GLYPH_HEIGHT (GLYPH_HEIGHT),
        .GLYPH_COUNT  (GLYPH_COUNT)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_cmd_valid     (fifo_valid),
        .i_cmd           (fifo_cmd),
        .o_cmd_pop       (cmd_pop),
        .o_tvalid        (m_axis_tvalid),
        .i_tready        (m_axis_tready),
        .o_pixel_address (pix_addr),
        .o_left_color    (left_col),
        .o_right_color   (right_col),
        .o_last_pair     (m_axis_tlast)
    );

    assign m_axis_tdata = {right_col, left_col, pix_addr};
endmodule
`default_nettype wire

### hw/rtl/tcgr_checker.sv
// port level checks of the glyph renderer, bound to the top level
`default_nettype none
module tcgr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [79:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);
    // a stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output beat changed");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // colors are white or a background value below 255
    a_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[55:32] == 24'hFFFFFF) ||
            ((m_axis_tdata[55:40] == 16'h0000) && (m_axis_tdata[39:32] != 8'hFF)))
        else $error("bad left color");

    a_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[79:56] == 24'hFFFFFF) ||
            ((m_axis_tdata[79:64] == 16'h0000) && (m_axis_tdata[63:56] != 8'hFF)))
        else $error("bad right color");
endmodule

bind text_console_glyph_renderer_unit tcgr_checker u_tcgr_checker (.*);
`default_nettype wire

### test/text_console_glyph_renderer_unit_tb.sv
// self-checking testbench of the text console glyph renderer: font loads, cursor moves, pixel pairs
`timescale 1ns / 1ps
module testbench;
    import tcgr_pkg::*;

    localparam int CELL_W = 8;
    localparam int CELL_H = 16;
    localparam int PAIRS_PER_ROW = (CELL_W + 1) / 2;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam logic MODE_CHAR = 1'b1;

    typedef struct packed {
        logic [31:0] addr;
        logic [23:0] left;
        logic [23:0] right;
        logic        last;
    } t_pixel_pair;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;  // char_code, font_row_index, font_row_bits, pad
    logic [0:0]  s_axis_tuser;  // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;  // pixel_address, left_color, right_color
    logic        m_axis_tlast;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_wdata;

    // shadow of the block: font, cursor and registers
    logic [7:0]  font_rows [0:FONT_DEPTH-1];
    bit          row_loaded [0:FONT_DEPTH-1];
    bit          glyph_usable [0:255];
    logic [7:0]  ready_glyphs [$];
    logic [15:0] cur_x;
    logic [15:0] cur_y;
    logic [31:0] cfg_frame_base;
    logic [15:0] cfg_line_pitch;
    logic [5:0]  cfg_bpp;
    logic [12:0] cfg_screen_width;

    t_pixel_pair pending_pairs [$];
    int          mismatch_count = 0;
    int          items_sent = 0;
    int          idle_cycles = 0;
    int          sink_hold = 0;
    bit          src_gaps_on = 1'b1;
    bit          sink_stalls_on = 1'b1;

    text_console_glyph_renderer_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // mostly short pauses, now and then a long one
    function automatic int stall_length();
        int r;
        r = $urandom_range(99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [23:0] shade(logic [7:0] rowbits, int col, logic [15:0] x,
                                          logic [15:0] y);
        logic [31:0] prod;
        prod = {16'd0, x} * {16'd0, y};
        if (rowbits[CELL_W - 1 - col]) return COLOR_WHITE;
        return 24'(prod % 32'd255);
    endfunction

    function automatic bit glyph_ready(logic [7:0] code);
        for (int r = 0; r < CELL_H; r++)
            if (!row_loaded[code * 16 + r]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic void render_glyph(logic [7:0] code);
        t_pixel_pair pp;
        logic [7:0]  rowbits;
        logic [15:0] x;
        logic [15:0] y;
        logic [31:0] byte_step;
        int          col;
        byte_step = {29'd0, cfg_bpp[5:3]};
        for (int r = 0; r < CELL_H; r++) begin
            rowbits = font_rows[code * 16 + r];
            y = cur_y + 16'(r);
            for (int p = 0; p < PAIRS_PER_ROW; p++) begin
                col = 2 * p;
                // odd widths: the last pair slides back to stay inside the glyph
                if (col + 1 >= CELL_W) col = CELL_W - 2;
                x = cur_x + 16'(col);
                pp.addr = cfg_frame_base + {16'd0, y} * {16'd0, cfg_line_pitch}
                          + {16'd0, x} * byte_step;
                pp.left = shade(rowbits, col, x, y);
                pp.right = shade(rowbits, col + 1, x + 16'd1, y);
                pp.last = (r == CELL_H - 1) && (p == PAIRS_PER_ROW - 1);
                pending_pairs.push_back(pp);
            end
        end
        cur_x = cur_x + 16'(CELL_W);
    endfunction

    function automatic void model_item(logic mode, logic [7:0] code, logic [3:0] row,
                                       logic [7:0] rowbits);
        if (mode == MODE_LOAD) begin
            font_rows[code * 16 + row] = rowbits;
            row_loaded[code * 16 + row] = 1'b1;
            if (!glyph_usable[code] && glyph_ready(code)) begin
                glyph_usable[code] = 1'b1;
                ready_glyphs.push_back(code);
            end
        end else if (code == CHAR_NEWLINE) begin
            cur_y = cur_y + 16'(CELL_H);
            cur_x = 16'd0;
        end else if (code == CHAR_RETURN) begin
            cur_x = 16'd0;
        end else if (code == CHAR_BACKSPACE) begin
            // at column zero wrap to the last cell of the line above
            if (cur_x == 16'd0) begin
                cur_y = cur_y - 16'(CELL_H);
                cur_x = {3'd0, cfg_screen_width} - 16'(CELL_W);
            end else begin
                cur_x = cur_x - 16'(CELL_W);
            end
            render_glyph(CHAR_SPACE);
            cur_x = cur_x - 16'(CELL_W);
        end else begin
            render_glyph(code);
        end
    endfunction

    task automatic note_mismatch(string field, logic [31:0] want_v, logic [31:0] got_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %s: expected %h, got %h at %0t", field, want_v, got_v, $time);
    endtask

    task automatic send_item(logic mode, logic [7:0] code, logic [3:0] row,
                             logic [7:0] rowbits);
        int gap;
        gap = (src_gaps_on && $urandom_range(99) < 40) ? stall_length() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        model_item(mode, code, row, rowbits);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'd0, rowbits, row, code};
        s_axis_tuser <= mode;
        items_sent++;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge i_clk);
        // loads and cursor moves give no beat and may still sit in the command queue
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_settings(logic [31:0] base, logic [15:0] pitch, logic [5:0] bpp,
                                  logic [12:0] width);
        cfg_frame_base = base;
        cfg_line_pitch = pitch;
        cfg_bpp = bpp;
        cfg_screen_width = width;
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_FRAME_BASE;
        i_cfg_wdata <= base;
        @(posedge i_clk);
        i_cfg_index <= CFG_LINE_PITCH;
        i_cfg_wdata <= {16'd0, pitch};
        @(posedge i_clk);
        i_cfg_index <= CFG_BPP;
        i_cfg_wdata <= {26'd0, bpp};
        @(posedge i_clk);
        i_cfg_index <= CFG_SCREEN_WIDTH;
        i_cfg_wdata <= {19'd0, width};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_glyph(logic [7:0] code);
        for (int r = 0; r < CELL_H; r++)
            send_item(MODE_LOAD, code, 4'(r), 8'($urandom_range(255)));
    endtask

    task automatic random_text(int count);
        int         stop_at;
        int         pick;
        logic [7:0] code;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(15) == 0) src_gaps_on = ($urandom_range(3) != 0);
            if ($urandom_range(15) == 0) sink_stalls_on = ($urandom_range(3) != 0);
            pick = $urandom_range(99);
            if (pick < 3) begin
                load_glyph(8'($urandom_range(255)));
            end else if (pick < 10) begin
                // stray row write, the glyph may never become complete
                send_item(MODE_LOAD, 8'($urandom_range(255)), 4'($urandom_range(15)),
                          8'($urandom_range(255)));
            end else if (pick < 16) begin
                send_item(MODE_CHAR, CHAR_NEWLINE, 4'($urandom_range(15)),
                          8'($urandom_range(255)));
            end else if (pick < 21) begin
                send_item(MODE_CHAR, CHAR_RETURN, 4'($urandom_range(15)),
                          8'($urandom_range(255)));
            end else if (pick < 28) begin
                send_item(MODE_CHAR, CHAR_BACKSPACE, 4'($urandom_range(15)),
                          8'($urandom_range(255)));
            end else begin
                code = ready_glyphs[$urandom_range(ready_glyphs.size() - 1)];
                send_item(MODE_CHAR, code, 4'($urandom_range(15)), 8'($urandom_range(255)));
            end
            if ($urandom_range(99) == 0) wait_for_drain();
        end
    endtask

    task automatic test_directed_text();
        logic [7:0] rowbits;
        for (int r = 0; r < CELL_H; r++) begin
            case (r)
                0: rowbits = 8'hFF;
                1: rowbits = 8'h00;
                2: rowbits = 8'h80;
                3: rowbits = 8'h01;
                default: rowbits = 8'($urandom_range(255));
            endcase
            send_item(MODE_LOAD, CHAR_SPACE, 4'(r), rowbits);
        end
        // back over a drawn cell, then back again from column zero onto line -1
        send_item(MODE_CHAR, CHAR_SPACE, 4'hF, 8'hFF);
        send_item(MODE_CHAR, CHAR_BACKSPACE, 4'h0, 8'h00);
        send_item(MODE_CHAR, CHAR_BACKSPACE, 4'hF, 8'hFF);
        send_item(MODE_CHAR, CHAR_NEWLINE, 4'h0, 8'h00);
        send_item(MODE_CHAR, CHAR_SPACE, 4'h5, 8'hA5);
        send_item(MODE_CHAR, CHAR_RETURN, 4'hA, 8'h5A);
        send_item(MODE_CHAR, CHAR_SPACE, 4'h3, 8'h3C);
    endtask

    task automatic test_extreme_settings();
        wait_for_drain();
        apply_settings(32'hFFFF_FFF8, 16'hFFFF, 6'd32, 13'd4096);
        load_glyph(8'h00);
        load_glyph(8'hFF);
        random_text(40);
    endtask

    task automatic test_narrow_screen();
        wait_for_drain();
        apply_settings($urandom, 16'd0, 6'd24, 13'd8);
        random_text(35);
    endtask

    task automatic test_odd_pixel_size();
        wait_for_drain();
        apply_settings($urandom, 16'($urandom_range(65535)), 6'($urandom_range(25, 31)),
                       13'($urandom_range(8, 4096)));
        random_text(20);
        wait_for_drain();
        random_text(20);
    endtask

    task automatic test_random_settings();
        repeat (2) begin
            wait_for_drain();
            apply_settings($urandom, 16'($urandom_range(65535)), 6'($urandom_range(24, 32)),
                           13'($urandom_range(8, 4096)));
            random_text(25);
        end
    endtask

    // sink side back pressure
    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            m_axis_tready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else if (sink_stalls_on && $urandom_range(99) < 20) begin
            m_axis_tready <= 1'b0;
            sink_hold <= stall_length() - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_pairs
        t_pixel_pair want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pairs.size() == 0) begin
                note_mismatch("unexpected beat, pixel_address", 32'd0, m_axis_tdata[31:0]);
            end else begin
                want = pending_pairs.pop_front();
                if (m_axis_tdata[31:0] !== want.addr)
                    note_mismatch("pixel_address", want.addr, m_axis_tdata[31:0]);
                if (m_axis_tdata[55:32] !== want.left)
                    note_mismatch("left_color", {8'd0, want.left}, {8'd0, m_axis_tdata[55:32]});
                if (m_axis_tdata[79:56] !== want.right)
                    note_mismatch("right_color", {8'd0, want.right},
                                  {8'd0, m_axis_tdata[79:56]});
                if (m_axis_tlast !== want.last)
                    note_mismatch("last_pair", {31'd0, want.last}, {31'd0, m_axis_tlast});
            end
        end
    end

    // watchdog: no beat on either side for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL text_console_glyph_renderer_unit");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        cur_x = 16'd0;
        cur_y = 16'd0;
        cfg_frame_base = RST_FRAME_BASE;
        cfg_line_pitch = RST_LINE_PITCH;
        cfg_bpp = RST_BPP;
        cfg_screen_width = RST_SCREEN_WIDTH;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_text();
        test_extreme_settings();
        test_narrow_screen();
        test_odd_pixel_size();
        test_random_settings();

        wait_for_drain();
        if (mismatch_count == 0 && pending_pairs.size() == 0) begin
            $display("PASS text_console_glyph_renderer_unit");
        end else begin
            $display("FAIL text_console_glyph_renderer_unit");
        end
        $finish;
    end

endmodule
